[design/swph_pkg.sv]
// Shared types and constants of the sliding window period histogram.
// Used by every module of the block but swph_ram; depends on nothing else.

package swph_pkg;

	// Default sizes of the histogram and of the ring of samples.
	localparam int NUM_BINS_DEF = 64;
	localparam int WINDOW_DEF   = 256;

	// Fixed widths of the port fields.
	localparam int PERIOD_W    = 16;
	localparam int QBIN_W      = 7;
	localparam int BIN_OUT_W   = 6;
	localparam int COUNT_OUT_W = 9;
	localparam int CFG_IDX_W   = 2;

	localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = 16'hFFFF;

	// Item kinds.
	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_PERIOD = 2'd0,
		CFG_ENABLED    = 2'd1
	} cfg_idx_t;

	// Input and output words.
	typedef struct packed {
		logic [1:0]          kind;
		logic [PERIOD_W-1:0] period;
		logic [QBIN_W-1:0]   query_bin;
	} in_word_t;

	typedef struct packed {
		logic [BIN_OUT_W-1:0]   bin;
		logic [COUNT_OUT_W-1:0] count;
	} out_word_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_ADD_RD,
		ST_ADD_INC,
		ST_OB_RD,
		ST_ADD_DEC,
		ST_Q_RD,
		ST_Q_LATCH,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic div_start;
		logic set_bin;
		logic ring_upd;
		logic inc_wr;
		logic ob_rd;
		logic dec_wr;
		logic q_rd;
		logic q_latch;
		logic clr_step;
		logic load_result;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  div_done;
		logic  enabled;
		logic  clr_last;
		logic  out_free;
	} dp_stat_t;

endpackage

[design/swph_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing else.

module swph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/swph_div.sv]
// Restoring divider that produces one quotient bit per cycle.
// Depends on swph_pkg for the period width.

module swph_div import swph_pkg::*; #(
	parameter int DVW = 22,
	parameter int QW  = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                zero_res,
	input  logic [DVW-1:0]      dividend,
	input  logic [PERIOD_W-1:0] divisor,
	output logic                done,
	output logic [QW-1:0]       quot
);

	localparam int CNT_W = $clog2(DVW + 1);

	logic [PERIOD_W-1:0] rem_q;
	logic [DVW-1:0]      dq_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;
	logic                ge;

	// One shift and trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, dq_q[DVW-1]};
		diff  = trial - {1'b0, divisor};
		ge    = (trial >= {1'b0, divisor});
	end

	// Iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= zero_res ? '0 : CNT_W'(DVW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Partial remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= zero_res ? '0 : dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
			dq_q  <= {dq_q[DVW-2:0], ge};
		end
	end

	assign done = (cnt_q == '0);
	assign quot = dq_q[QW-1:0];

endmodule

[design/swph_ctrl.sv]
// Controller state machine of the sliding window period histogram.
// Depends on swph_pkg for the state, command and status types.

module swph_ctrl import swph_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register; reset starts with the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.kind)
					KIND_ADD: begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end
					KIND_QUERY: state_d = ST_Q_RD;
					KIND_CLEAR: state_d = ST_CLEAR;
					KIND_NOP:   state_d = ST_DONE;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.set_bin = 1'b1;
					state_d     = stat.enabled ? ST_ADD_RD : ST_DONE;
				end
			end
			ST_ADD_RD: begin
				cmd.ring_upd = 1'b1;
				state_d      = ST_ADD_INC;
			end
			ST_ADD_INC: begin
				cmd.inc_wr = 1'b1;
				state_d    = ST_OB_RD;
			end
			ST_OB_RD: begin
				cmd.ob_rd = 1'b1;
				state_d   = ST_ADD_DEC;
			end
			ST_ADD_DEC: begin
				cmd.dec_wr = 1'b1;
				state_d    = ST_DONE;
			end
			ST_Q_RD: begin
				cmd.q_rd = 1'b1;
				state_d  = ST_Q_LATCH;
			end
			ST_Q_LATCH: begin
				cmd.q_latch = 1'b1;
				state_d     = ST_DONE;
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

endmodule

[design/swph_dp.sv]
// Datapath: configuration registers, divider, ring and count memories, output register.
// Depends on swph_pkg, swph_ram and swph_div.

module swph_dp import swph_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF,
	parameter int WINDOW   = WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_word_t             in_data,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_data,
	input  ctrl_cmd_t            cmd,
	output dp_stat_t             stat
);

	localparam int BW    = $clog2(NUM_BINS);
	localparam int CW    = $clog2(WINDOW + 1);
	localparam int PW    = $clog2(WINDOW);
	localparam int SWEEP = (WINDOW > NUM_BINS) ? WINDOW : NUM_BINS;
	localparam int SW    = $clog2(SWEEP);
	localparam int DVW   = PERIOD_W + BW;

	logic [PERIOD_W-1:0] max_period_q;
	logic                enabled_q;
	in_word_t            in_q;
	out_word_t           res_q;
	out_word_t           out_q;
	logic                out_valid_q;
	logic [PW-1:0]       ptr_q;
	logic [PW-1:0]       ptr_next;
	logic [BW-1:0]       ob_q;
	logic [SW-1:0]       clr_idx_q;
	logic                clr_last;

	logic [DVW-1:0]      dividend;
	logic                zero_res;
	logic                div_done;
	logic [BW-1:0]       nb;

	logic [BW-1:0]       qaddr;
	logic                q_ok;

	logic                cnt_we;
	logic [BW-1:0]       cnt_waddr;
	logic [CW-1:0]       cnt_wdata;
	logic [BW-1:0]       cnt_raddr;
	logic [CW-1:0]       cnt_rdata;

	logic                ring_we;
	logic [PW-1:0]       ring_waddr;
	logic [BW-1:0]       ring_wdata;
	logic [BW-1:0]       ring_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_period_q <= MAX_PERIOD_RST;
			enabled_q    <= 1'b1;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_MAX_PERIOD) begin
				max_period_q <= cfg_data;
			end else if (cfg_index == CFG_ENABLED) begin
				enabled_q <= cfg_data[0];
			end
		end
	end

	// Captured input word.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_data;
		end
	end

	// Bin computation: NUM_BINS * period / max_period, zero at or above max_period.
	assign dividend = DVW'(in_q.period) * DVW'(NUM_BINS);
	assign zero_res = (in_q.period >= max_period_q);

	swph_div #(
		.DVW(DVW),
		.QW (BW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.zero_res(zero_res),
		.dividend(dividend),
		.divisor (max_period_q),
		.done    (div_done),
		.quot    (nb)
	);

	// Ring pointer and the bin that leaves the window.
	assign ptr_next = (32'(ptr_q) == WINDOW - 1) ? '0 : ptr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.clr_step) begin
			ptr_q <= '0;
		end else if (cmd.dec_wr) begin
			ptr_q <= ptr_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.inc_wr) begin
			ob_q <= ring_rdata;
		end
	end

	// Clearing sweep over both memories.
	assign clr_last = (32'(clr_idx_q) == SWEEP - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			clr_idx_q <= clr_last ? '0 : clr_idx_q + 1'b1;
		end
	end

	// Count memory port selection.
	assign qaddr = BW'(in_q.query_bin);
	assign q_ok  = (32'(in_q.query_bin) < NUM_BINS) && enabled_q;

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = nb;
		cnt_wdata = cnt_rdata + 1'b1;
		if (cmd.clr_step) begin
			cnt_we    = (32'(clr_idx_q) < NUM_BINS);
			cnt_waddr = clr_idx_q[BW-1:0];
			cnt_wdata = (clr_idx_q == '0) ? CW'(WINDOW) : '0;
		end else if (cmd.inc_wr) begin
			cnt_we = 1'b1;
		end else if (cmd.dec_wr) begin
			cnt_we    = 1'b1;
			cnt_waddr = ob_q;
			cnt_wdata = cnt_rdata - 1'b1;
		end
	end

	always_comb begin
		if (cmd.q_rd) begin
			cnt_raddr = qaddr;
		end else if (cmd.ob_rd) begin
			cnt_raddr = ob_q;
		end else begin
			cnt_raddr = nb;
		end
	end

	swph_ram #(
		.WIDTH(CW),
		.DEPTH(NUM_BINS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	// Ring memory port selection.
	always_comb begin
		if (cmd.clr_step) begin
			ring_we    = (32'(clr_idx_q) < WINDOW);
			ring_waddr = clr_idx_q[PW-1:0];
			ring_wdata = '0;
		end else begin
			ring_we    = cmd.ring_upd;
			ring_waddr = ptr_q;
			ring_wdata = nb;
		end
	end

	swph_ram #(
		.WIDTH(BW),
		.DEPTH(WINDOW)
	) u_ring_ram (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wdata),
		.raddr(ptr_next),
		.rdata(ring_rdata)
	);

	// Result fields as the item proceeds.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_q <= '0;
		end else if (cmd.set_bin) begin
			res_q.bin <= BIN_OUT_W'(nb);
		end else if (cmd.q_latch) begin
			res_q.bin   <= in_q.query_bin[BIN_OUT_W-1:0];
			res_q.count <= q_ok ? COUNT_OUT_W'(cnt_rdata) : '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status to the controller.
	assign stat.kind     = kind_t'(in_q.kind);
	assign stat.div_done = div_done;
	assign stat.enabled  = enabled_q;
	assign stat.clr_last = clr_last;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

[design/sliding_window_period_histogram.sv]
// Sliding window period histogram: one word in, one word out, one item at a time. An add
// first finds its bin with the divider, which produces one quotient bit per cycle, and
// then, if enabled, does a read-modify-write on the count memory. A clear item, and the
// clearing pass after reset, sweep max(WINDOW, NUM_BINS) memory addresses (256 at the
// defaults) while no word is accepted; configuration writes are taken at any time and
// should be made only while the block is idle. A finished result waits in an output
// register, and the next word is accepted while it waits.
// Depends on swph_pkg, swph_ctrl and swph_dp.

module sliding_window_period_histogram import swph_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF,
	parameter int WINDOW   = WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Configuration writes are always accepted.
	assign cfg_ready = 1'b1;

	swph_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	swph_dp #(
		.NUM_BINS(NUM_BINS),
		.WINDOW  (WINDOW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
